### hdl/rotated_framebuffer_pixel_writer_core_defines.svh
// Assertion macros for the rotated framebuffer pixel writer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ROTATED_FRAMEBUFFER_PIXEL_WRITER_CORE_DEFINES_SVH
`define ROTATED_FRAMEBUFFER_PIXEL_WRITER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFPW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// next-cycle implication
`define RFPW_ASSERT_NEXT(label, pre, post, msg) \
	`RFPW_ASSERT(label, (pre) |=> (post), msg)

`endif

### hdl/rfpw_pkg.sv
// Shared types and constants of the rotated framebuffer pixel writer.
// No dependencies; used by the interfaces, the core and its checker.
package rfpw_pkg;

	localparam int ACT_W      = 2;
	localparam int COORD_W    = 8;
	localparam int BADDR_W    = 13;
	localparam int DATA_W     = 8;
	localparam int DIM_W      = 9;
	localparam int STRIDE_W   = 6;
	localparam int AREA_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam int MAX_DIM_DEF = 256;

	localparam logic [DIM_W-1:0]  WIDTH_RST  = 9'd200;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 9'd200;
	localparam logic [DATA_W-1:0] PIX_MSB    = 8'h80;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_OOR  = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET  = 2'd0,
		ACT_FILL = 2'd1,
		ACT_READ = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2
	} cfg_reg_t;

endpackage

### hdl/rfpw_intf.sv
// Valid/ready channel interfaces of the rotated framebuffer pixel writer:
// item requests, results and configuration writes. Depends on rfpw_pkg.
interface rfpw_req_if;
	logic                              valid;
	logic                              ready;
	logic [rfpw_pkg::ACT_W-1:0]        action;
	logic [rfpw_pkg::COORD_W-1:0]      x;
	logic [rfpw_pkg::COORD_W-1:0]      y;
	logic                              color;
	logic [rfpw_pkg::DATA_W-1:0]       fill_byte;
	logic [rfpw_pkg::BADDR_W-1:0]      byte_addr;

	modport source (output valid, action, x, y, color, fill_byte, byte_addr, input ready);
	modport sink   (input valid, action, x, y, color, fill_byte, byte_addr, output ready);
endinterface

interface rfpw_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [rfpw_pkg::DATA_W-1:0]       read_data;
	logic                              status;

	modport source (output valid, read_data, status, input ready);
	modport sink   (input valid, read_data, status, output ready);
endinterface

interface rfpw_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rfpw_pkg::CFG_IDX_W-1:0]    index;
	logic [rfpw_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hdl/rotated_framebuffer_pixel_writer_core.sv
// Rotated 1-bit-per-pixel frame memory writer: top level.
// Depends on rfpw_pkg and the channel interfaces in rfpw_intf.sv.
//
// Keeps a monochrome frame in one synchronous byte memory (one read port,
// one write port, registered read), rows of ceil(width/8) bytes, MSB
// first. Set-pixel and read items run through two stages: the first rotates
// the coordinates, checks bounds and issues the memory read, the second
// modifies the byte and writes it back, with the last write forwarded to a
// read of the same byte. These items are taken one per cycle unless a held
// result stalls them. A fill holds the second stage until stride*height
// bytes are written, one byte per cycle through the single write port; no
// new item is taken meanwhile. The memory has no reset: a byte must be
// filled or written before it is read. Configuration writes are taken
// every cycle and must only be made while no item is in flight.
module rotated_framebuffer_pixel_writer_core #(
	parameter int MAX_DIM = rfpw_pkg::MAX_DIM_DEF
) (
	input logic      clk,
	input logic      arst_n,
	rfpw_req_if.sink req,
	rfpw_rsp_if.source rsp,
	rfpw_cfg_if.sink cfg
);
	import rfpw_pkg::*;

	localparam int MemDepth = ((MAX_DIM + 7) / 8) * MAX_DIM;
	localparam int AW       = $clog2(MemDepth);
	localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

	// configuration
	rot_t             rot_q;
	logic [DIM_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q    <= ROT_0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ROTATION: rot_q    <= rot_t'(cfg.data[1:0]);
				REG_WIDTH:    width_q  <= cfg.data;
				REG_HEIGHT:   height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// derived geometry
	logic [DIM_W-1:0]    w_eff, h_eff;
	logic [STRIDE_W-1:0] stride;
	logic [AREA_W-1:0]   area;

	assign w_eff  = (width_q > MaxDim) ? MaxDim : width_q;
	assign h_eff  = (height_q > MaxDim) ? MaxDim : height_q;
	assign stride = STRIDE_W'((w_eff + 9'd7) >> 3);
	assign area   = {{(AREA_W-STRIDE_W){1'b0}}, stride} * {{(AREA_W-DIM_W){1'b0}}, h_eff};

	// stage 0: rotation, bounds, address
	logic signed [9:0] xs, ys, ws, hs, px, py;
	logic              pix_ok, rd_ok;
	logic [13:0]       pix_sum;
	logic [AW-1:0]     addr_s0;
	logic              oor_s0;

	always_comb begin
		xs = $signed({2'b00, req.x});
		ys = $signed({2'b00, req.y});
		ws = $signed({1'b0, w_eff});
		hs = $signed({1'b0, h_eff});
		unique case (rot_q)
			ROT_0: begin
				px = xs;
				py = ys;
			end
			ROT_90: begin
				px = ws - 10'sd1 - ys;
				py = xs;
			end
			ROT_180: begin
				px = ws - 10'sd1 - xs;
				py = hs - 10'sd1 - ys;
			end
			ROT_270: begin
				px = ys;
				py = hs - 10'sd1 - xs;
			end
			default: begin
				px = xs;
				py = ys;
			end
		endcase
		pix_ok  = !px[9] && (px < ws) && !py[9] && (py < hs);
		pix_sum = {9'd0, px[7:3]} + ({6'd0, py[7:0]} * {8'd0, stride});
		rd_ok   = {{(AREA_W-BADDR_W){1'b0}}, req.byte_addr} < area;
		case (req.action)
			ACT_SET: begin
				addr_s0 = pix_sum[AW-1:0];
				oor_s0  = !pix_ok;
			end
			ACT_FILL: begin
				addr_s0 = pix_sum[AW-1:0];
				oor_s0  = ST_DONE;
			end
			ACT_READ: begin
				addr_s0 = req.byte_addr[AW-1:0];
				oor_s0  = !rd_ok;
			end
			default: begin
				addr_s0 = pix_sum[AW-1:0];
				oor_s0  = ST_OOR;
			end
		endcase
	end

	// stage 1 registers
	logic                s1_v;
	logic [ACT_W-1:0]    act_s1;
	logic [AW-1:0]       addr_s1;
	logic [DATA_W-1:0]   mask_s1, fbyte_s1, rd_s1;
	logic                color_s1, oor_s1;
	logic                s1_go, req_xfer, out_v_q;
	logic [AW-1:0]       fill_index_q;
	logic                fill_done;

	assign req_xfer  = req.valid && req.ready;
	assign fill_done = (area == '0) ||
		({{(AREA_W-AW){1'b0}}, fill_index_q} == (area - AREA_W'(1)));
	assign s1_go     = s1_v && (!out_v_q || rsp.ready) &&
		((act_s1 != ACT_FILL) || fill_done);
	assign req.ready = !s1_v || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (req_xfer) begin
			s1_v <= 1'b1;
		end else if (s1_go) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			act_s1   <= req.action;
			addr_s1  <= addr_s0;
			mask_s1  <= PIX_MSB >> px[2:0];
			color_s1 <= req.color;
			fbyte_s1 <= req.fill_byte;
			oor_s1   <= oor_s0;
		end
	end

	// frame memory
	logic [DATA_W-1:0] frame_mem [MemDepth];
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata, cur_byte;
	logic              fill_we;
	logic              wr_v_q;
	logic [AW-1:0]     wr_addr_q;
	logic [DATA_W-1:0] wr_data_q;

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			rd_s1 <= frame_mem[addr_s0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			frame_mem[waddr] <= wdata;
		end
	end

	assign cur_byte = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_s1;
	assign fill_we  = s1_v && (act_s1 == ACT_FILL) && (area != '0);

	always_comb begin
		if (fill_we) begin
			we    = 1'b1;
			waddr = fill_index_q;
			wdata = fbyte_s1;
		end else begin
			we    = s1_go && (act_s1 == ACT_SET) && !oor_s1;
			waddr = addr_s1;
			wdata = color_s1 ? (cur_byte | mask_s1) : (cur_byte & ~mask_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q       <= 1'b0;
			fill_index_q <= '0;
		end else begin
			if (we) begin
				wr_v_q <= 1'b1;
			end
			if (s1_go) begin
				fill_index_q <= '0;
			end else if (fill_we && !fill_done) begin
				fill_index_q <= fill_index_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wr_addr_q <= waddr;
			wr_data_q <= wdata;
		end
	end

	// result register
	logic [DATA_W-1:0] rdata_q;
	logic              status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			rdata_q  <= ((act_s1 == ACT_READ) && !oor_s1) ? cur_byte : '0;
			status_q <= oor_s1;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.read_data = rdata_q;
	assign rsp.status    = status_q;

endmodule

### hdl/rfpw_chk.sv
// Port-level checker for the rotated framebuffer pixel writer, bound to the
// top level. Depends on rfpw_pkg, rfpw_intf.sv and the defines header.
`include "rotated_framebuffer_pixel_writer_core_defines.svh"

module rfpw_chk (
	input logic        clk,
	input logic        arst_n,
	rfpw_req_if.sink   req,
	rfpw_rsp_if.source rsp,
	rfpw_cfg_if.sink   cfg
);
	import rfpw_pkg::*;

	logic [1:0] pending_q;
	logic       req_xfer, rsp_xfer;

	assign req_xfer = req.valid && req.ready;
	assign rsp_xfer = rsp.valid && rsp.ready;

	// items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_xfer && !req_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`RFPW_ASSERT(a_no_phantom_result, rsp.valid |-> (pending_q != 2'd0), "result with no item pending")
	`RFPW_ASSERT(a_pending_bound, pending_q <= 2'd2, "more than two items in flight")
	`RFPW_ASSERT(a_oor_zero_data, (rsp.valid && (rsp.status == ST_OOR)) |-> (rsp.read_data == '0), "rejected item returned data")
	`RFPW_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.read_data) && $stable(rsp.status), "stalled result changed")
	`RFPW_ASSERT(a_cfg_ready, cfg.valid |-> cfg.ready, "register write refused")

endmodule

bind rotated_framebuffer_pixel_writer_core rfpw_chk u_rfpw_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp),
	.cfg    (cfg)
);
